// ===== src/cdas_pkg.sv =====
// cdas_pkg: shared types and constants for the Gregorian date add/subtract core.
// Used by cdas_ctrl, cdas_dp and calendar_date_add_subtract_days_core.
// No dependencies.
package cdas_pkg;

    typedef enum logic [1:0] {
        CMD_LOAD = 2'd0,
        CMD_ADD  = 2'd1,
        CMD_SUB  = 2'd2,
        CMD_NONE = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD_Q,
        S_LOAD_SET,
        S_WALK,
        S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic capture;   // item accepted: latch fields, form day offset
        logic load_q;    // register year/25 quotient
        logic load_set;  // write repaired load date
        logic step;      // walk one month
        logic finish;    // write walked day back
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic stop;      // no further month step needed
    } t_dp_sts;

    localparam logic [15:0] YEAR_TOP      = 16'hFFFF;
    localparam logic [3:0]  MONTH_DEC     = 4'd12;
    localparam logic [3:0]  MONTH_JAN     = 4'd1;
    localparam logic [3:0]  MONTH_FEB     = 4'd2;
    localparam logic [4:0]  FEB_LEAP_LEN  = 5'd29;
    localparam logic [4:0]  DEC_LEN       = 5'd31;
    localparam logic [4:0]  MOD25_LAST    = 5'd24;
    localparam int          YEAR_TOP_INT  = 65535;
    // floor(y/25) = (y * RECIP25) >> RECIP25_SHIFT, exact for 16-bit y
    localparam int          RECIP25_SHIFT = 21;
    localparam logic [16:0] RECIP25       = 17'd83887;

    // month lengths, index 0 is the zero date
    function automatic logic [4:0] month_len(input logic [3:0] m);
        logic [4:0] len;
        case (m) inside
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

// ===== src/calendar_date_add_subtract_days_core.sv =====
// Gregorian date register with signed day add/subtract, one month walked per cycle.
// Load steps through the quotient and repaired-date write states before o_done; cmd 3
// goes straight to o_done; add/subtract walks months until the day fits or the date
// clamps, then writes the day back and strobes o_done. Next item may start the cycle after o_done.
// Synchronous active-low reset gives date 0-01-01; o_done is a one-cycle strobe.
// Depends on cdas_pkg, cdas_ctrl, cdas_dp.
module calendar_date_add_subtract_days_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_cmd,
    input  logic [15:0] i_load_year,
    input  logic [3:0]  i_load_month,
    input  logic [4:0]  i_load_day,
    input  logic [15:0] i_delta_days,
    output logic        o_done,
    output logic [15:0] o_out_year,
    output logic [3:0]  o_out_month,
    output logic [4:0]  o_out_day,
    output logic        o_clamped
);

    cdas_pkg::t_dp_cmd dp_cmd;
    cdas_pkg::t_dp_sts dp_sts;

    cdas_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_cmd    (i_cmd),
        .i_sts    (dp_sts),
        .o_dp_cmd (dp_cmd),
        .o_busy   (busy),
        .o_done   (o_done)
    );

    cdas_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_dp_cmd     (dp_cmd),
        .i_cmd        (i_cmd),
        .i_load_year  (i_load_year),
        .i_load_month (i_load_month),
        .i_load_day   (i_load_day),
        .i_delta_days (i_delta_days),
        .o_sts        (dp_sts),
        .o_year       (o_out_year),
        .o_month      (o_out_month),
        .o_day        (o_out_day),
        .o_clamped    (o_clamped)
    );

endmodule

// ===== src/cdas_ctrl.sv =====
// cdas_ctrl: sequencing FSM for load, month walk and result strobe.
// Depends on cdas_pkg (state enum, command/status structs).
module cdas_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [1:0]       i_cmd,
    input  cdas_pkg::t_dp_sts i_sts,
    output cdas_pkg::t_dp_cmd o_dp_cmd,
    output logic             o_busy,
    output logic             o_done
);

    cdas_pkg::t_state r_state;
    cdas_pkg::t_state n_state;
    logic             accept;

    assign accept = i_start && (r_state == cdas_pkg::S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cdas_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cdas_pkg::S_IDLE: begin
                if (i_start) begin
                    unique case (cdas_pkg::t_cmd'(i_cmd)) inside
                        cdas_pkg::CMD_LOAD:                  n_state = cdas_pkg::S_LOAD_Q;
                        cdas_pkg::CMD_ADD, cdas_pkg::CMD_SUB: n_state = cdas_pkg::S_WALK;
                        default:                             n_state = cdas_pkg::S_DONE;
                    endcase
                end
            end
            cdas_pkg::S_LOAD_Q:   n_state = cdas_pkg::S_LOAD_SET;
            cdas_pkg::S_LOAD_SET: n_state = cdas_pkg::S_DONE;
            cdas_pkg::S_WALK: begin
                if (i_sts.stop) begin
                    n_state = cdas_pkg::S_DONE;
                end
            end
            cdas_pkg::S_DONE:     n_state = cdas_pkg::S_IDLE;
            default:              n_state = cdas_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_dp_cmd          = '0;
        o_dp_cmd.capture  = accept;
        o_dp_cmd.load_q   = (r_state == cdas_pkg::S_LOAD_Q);
        o_dp_cmd.load_set = (r_state == cdas_pkg::S_LOAD_SET);
        o_dp_cmd.step     = (r_state == cdas_pkg::S_WALK) && !i_sts.stop;
        o_dp_cmd.finish   = (r_state == cdas_pkg::S_WALK) && i_sts.stop;
        o_busy            = (r_state != cdas_pkg::S_IDLE);
        o_done            = (r_state == cdas_pkg::S_DONE);
    end

    // one strobe per item, then ready again
    a_done_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_busy)
        else $error("strobe not followed by idle");

    a_walk_ends_in_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_dp_cmd.finish |=> o_done)
        else $error("walk finish without result strobe");

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_dp_cmd.capture, o_dp_cmd.load_q, o_dp_cmd.load_set,
                  o_dp_cmd.step, o_dp_cmd.finish}))
        else $error("overlapping datapath commands");

endmodule

// ===== src/cdas_dp.sv =====
// cdas_dp: date registers, year mod 25 tracker, load repair and one-month walk step.
// Depends on cdas_pkg (structs, month table, constants).
module cdas_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cdas_pkg::t_dp_cmd i_dp_cmd,
    input  logic [1:0]        i_cmd,
    input  logic [15:0]       i_load_year,
    input  logic [3:0]        i_load_month,
    input  logic [4:0]        i_load_day,
    input  logic [15:0]       i_delta_days,
    output cdas_pkg::t_dp_sts o_sts,
    output logic [15:0]       o_year,
    output logic [3:0]        o_month,
    output logic [4:0]        o_day,
    output logic              o_clamped
);

    // committed date; r_mod25 is year mod 25 for the leap test
    logic [15:0]        r_year;
    logic [3:0]         r_month;
    logic [4:0]         r_day;
    logic [4:0]         r_mod25;
    logic               r_flag;
    // walk working set
    logic signed [16:0] r_t;
    logic               r_fwd;
    // load working set
    logic [15:0]        r_ld_year;
    logic [3:0]         r_ld_month;
    logic [4:0]         r_ld_day;
    logic [11:0]        r_q;

    logic [15:0]        n_year;
    logic [3:0]         n_month;
    logic [4:0]         n_day;
    logic [4:0]         n_mod25;
    logic               n_flag;
    logic signed [16:0] n_t;

    logic signed [16:0] delta17;
    logic signed [16:0] offs17;
    logic [32:0]        prod;
    logic [15:0]        q_x25;
    logic [15:0]        rem16;
    logic [4:0]         ld_mod25;
    logic               ld_leap;
    logic [3:0]         ld_m;
    logic [4:0]         ld_len;
    logic [4:0]         ld_d;
    logic               cur_leap;
    logic [4:0]         cur_len;
    logic [3:0]         prev_m;
    logic [4:0]         prev_len;
    logic signed [16:0] cur_len17;

    function automatic logic is_leap(input logic [15:0] y, input logic [4:0] m25);
        // div by 100 <=> div by 4 and 25; div by 400 <=> div by 16 and 25
        return (y[1:0] == 2'b00) && ((m25 != 5'd0) || (y[3:0] == 4'b0000));
    endfunction

    function automatic logic [4:0] days_in(input logic [3:0] m, input logic leap);
        if (m == cdas_pkg::MONTH_FEB && leap) begin
            return cdas_pkg::FEB_LEAP_LEN;
        end
        return cdas_pkg::month_len(m);
    endfunction

    // day offset for the walk
    assign delta17 = {i_delta_days[15], i_delta_days};
    assign offs17  = (cdas_pkg::t_cmd'(i_cmd) == cdas_pkg::CMD_SUB) ? -delta17 : delta17;

    // load path: year mod 25 via reciprocal multiply
    assign prod     = 33'(r_ld_year) * 33'(cdas_pkg::RECIP25);
    assign q_x25    = ({4'b0, r_q} << 4) + ({4'b0, r_q} << 3) + {4'b0, r_q};
    assign rem16    = r_ld_year - q_x25;
    assign ld_mod25 = rem16[4:0];
    assign ld_leap  = is_leap(r_ld_year, ld_mod25);
    assign ld_m     = (r_ld_month == 4'd0) ? cdas_pkg::MONTH_JAN :
                      (r_ld_month > cdas_pkg::MONTH_DEC) ? cdas_pkg::MONTH_DEC : r_ld_month;
    assign ld_len   = days_in(ld_m, ld_leap);
    assign ld_d     = (r_ld_day == 5'd0) ? 5'd1 : (r_ld_day > ld_len) ? ld_len : r_ld_day;

    // walk path
    assign cur_leap  = is_leap(r_year, r_mod25);
    assign cur_len   = days_in(r_month, cur_leap);
    assign cur_len17 = signed'({12'b0, cur_len});
    assign prev_m    = r_month - 4'd1;
    assign prev_len  = days_in(prev_m, cur_leap);

    assign o_sts.stop = r_flag || (r_fwd ? (r_t <= cur_len17) : (r_t > 17'sd0));

    always_comb begin
        n_year  = r_year;
        n_month = r_month;
        n_day   = r_day;
        n_mod25 = r_mod25;
        n_flag  = r_flag;
        n_t     = r_t;
        if (i_dp_cmd.capture) begin
            n_flag = 1'b0;
            n_t    = signed'({12'b0, r_day}) + offs17;
        end
        if (i_dp_cmd.load_set) begin
            n_year  = r_ld_year;
            n_month = ld_m;
            n_day   = ld_d;
            n_mod25 = ld_mod25;
        end
        if (i_dp_cmd.step) begin
            if (r_fwd) begin
                n_t = r_t - cur_len17;
                if (r_month == cdas_pkg::MONTH_DEC) begin
                    if (r_year == cdas_pkg::YEAR_TOP) begin
                        // saturate at the last representable day
                        n_month = cdas_pkg::MONTH_DEC;
                        n_t     = signed'({12'b0, cdas_pkg::DEC_LEN});
                        n_flag  = 1'b1;
                    end else begin
                        n_year  = r_year + 16'd1;
                        n_month = cdas_pkg::MONTH_JAN;
                        n_mod25 = (r_mod25 == cdas_pkg::MOD25_LAST) ? 5'd0 : r_mod25 + 5'd1;
                    end
                end else begin
                    n_month = r_month + 4'd1;
                end
            end else begin
                if (r_month <= cdas_pkg::MONTH_JAN) begin
                    if (r_year == 16'd0) begin
                        // underflow clears to the zero date
                        n_month = 4'd0;
                        n_t     = 17'sd0;
                        n_mod25 = 5'd0;
                        n_flag  = 1'b1;
                    end else begin
                        n_year  = r_year - 16'd1;
                        n_month = cdas_pkg::MONTH_DEC;
                        n_mod25 = (r_mod25 == 5'd0) ? cdas_pkg::MOD25_LAST : r_mod25 - 5'd1;
                        n_t     = r_t + signed'({12'b0, cdas_pkg::DEC_LEN});
                    end
                end else begin
                    n_month = prev_m;
                    n_t     = r_t + signed'({12'b0, prev_len});
                end
            end
        end
        if (i_dp_cmd.finish) begin
            n_day = r_t[4:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_year  <= '0;
            r_month <= cdas_pkg::MONTH_JAN;
            r_day   <= 5'd1;
            r_mod25 <= '0;
            r_flag  <= 1'b0;
        end else begin
            r_year  <= n_year;
            r_month <= n_month;
            r_day   <= n_day;
            r_mod25 <= n_mod25;
            r_flag  <= n_flag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t <= n_t;
        if (i_dp_cmd.capture) begin
            r_fwd      <= !offs17[16];
            r_ld_year  <= i_load_year;
            r_ld_month <= i_load_month;
            r_ld_day   <= i_load_day;
        end
        if (i_dp_cmd.load_q) begin
            r_q <= prod[cdas_pkg::RECIP25_SHIFT +: 12];
        end
    end

    assign o_year    = r_year;
    assign o_month   = r_month;
    assign o_day     = r_day;
    assign o_clamped = r_flag;

    a_mod25_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mod25 <= cdas_pkg::MOD25_LAST)
        else $error("year mod 25 tracker out of range");

    a_month_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_month <= cdas_pkg::MONTH_DEC)
        else $error("month out of range");

    a_step_not_stopped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_dp_cmd.step |-> !o_sts.stop)
        else $error("month step issued after walk finished");

    a_fwd_positive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_dp_cmd.step && r_fwd) |=> !r_t[16])
        else $error("forward walk drove day offset negative");

endmodule

// ===== verif/calendar_date_add_subtract_days_core_test.sv =====
// Self-checking testbench for calendar_date_add_subtract_days_core: date loads, day add/subtract,
// underflow and saturation, checked against an in-bench date predictor. Depends on cdas_pkg
// and the core RTL only.
module calendar_date_add_subtract_days_core_test;

    localparam int CLK_HALF      = 4;
    localparam int STALL_LIMIT   = 10000;
    localparam int RANDOM_ITEMS  = 500;
    localparam int IDLE_PERCENT  = 33;
    localparam int CALM_FIRST    = 250;
    localparam int CALM_LAST     = 350;
    localparam int MONTH_DAYS [13] = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    typedef struct {
        cdas_pkg::t_cmd op;
        logic [15:0]    year;
        logic [3:0]     month;
        logic [4:0]     day;
        logic [15:0]    delta;
        bit             drain;    // hold off until every result is back
    } t_cmd_item;

    typedef struct {
        logic [15:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic        clamped;
    } t_date;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_cmd;
    logic [15:0] i_load_year;
    logic [3:0]  i_load_month;
    logic [4:0]  i_load_day;
    logic [15:0] i_delta_days;
    logic        o_done;
    logic [15:0] o_out_year;
    logic [3:0]  o_out_month;
    logic [4:0]  o_out_day;
    logic        o_clamped;

    t_cmd_item cmd_queue [$];
    t_date     due_dates [$];
    t_date     held_date;
    bit        armed;
    bit        taken;
    int        items_sent;
    int        stall_cycles;
    int        errors;

    calendar_date_add_subtract_days_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_cmd        (i_cmd),
        .i_load_year  (i_load_year),
        .i_load_month (i_load_month),
        .i_load_day   (i_load_day),
        .i_delta_days (i_delta_days),
        .o_done       (o_done),
        .o_out_year   (o_out_year),
        .o_out_month  (o_out_month),
        .o_out_day    (o_out_day),
        .o_clamped    (o_clamped)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    function automatic int days_in_month(int y, int m);
        if (m < 1 || m > 12)
            return 0;
        if (m == 2 && ((y % 4 == 0 && y % 100 != 0) || y % 400 == 0))
            return cdas_pkg::FEB_LEAP_LEN;
        return MONTH_DAYS[m];
    endfunction

    // date held after one item; clamped marks underflow or saturation on this item
    function automatic t_date advance_date(t_date now, cdas_pkg::t_cmd op, logic [15:0] ly,
                                           logic [3:0] lm, logic [4:0] ld, logic [15:0] dd);
        t_date next;
        int    y;
        int    m;
        int    t;
        int    step;
        int    len;
        next = now;
        next.clamped = 1'b0;
        case (op) inside
            cdas_pkg::CMD_LOAD: begin
                y = ly;
                m = lm;
                t = ld;
                if (m < 1) m = 1;
                if (m > 12) m = 12;
                len = days_in_month(y, m);
                if (t < 1) t = 1;
                if (t > len) t = len;
                next.year  = y[15:0];
                next.month = m[3:0];
                next.day   = t[4:0];
            end
            cdas_pkg::CMD_ADD, cdas_pkg::CMD_SUB: begin
                y = now.year;
                m = now.month;
                step = $signed(dd);
                if (op == cdas_pkg::CMD_SUB)
                    step = -step;
                t = int'(now.day) + step;
                if (step >= 0) begin
                    while (t > days_in_month(y, m)) begin
                        t -= days_in_month(y, m);
                        m++;
                        if (m > 12) begin
                            m = 1;
                            y++;
                            if (y > cdas_pkg::YEAR_TOP_INT) begin
                                y = cdas_pkg::YEAR_TOP_INT;
                                m = 12;
                                t = cdas_pkg::DEC_LEN;
                                next.clamped = 1'b1;
                                break;
                            end
                        end
                    end
                end else begin
                    while (t <= 0) begin
                        m--;
                        if (m < 1) begin
                            m = 12;
                            y--;
                            if (y < 0) begin
                                y = 0;
                                m = 0;
                                t = 0;
                                next.clamped = 1'b1;
                                break;
                            end
                        end
                        t += days_in_month(y, m);
                    end
                end
                next.year  = y[15:0];
                next.month = m[3:0];
                next.day   = t[4:0];
            end
            default: ;
        endcase
        return next;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
        errors++;
    endtask

    task automatic queue_item(cdas_pkg::t_cmd op, int y, int m, int d, int delta,
                              bit drain = 1'b0);
        t_cmd_item it;
        it.op    = op;
        it.year  = y[15:0];
        it.month = m[3:0];
        it.day   = d[4:0];
        it.delta = delta[15:0];
        it.drain = drain;
        cmd_queue.push_back(it);
    endtask

    function automatic int pick_year();
        int r;
        r = $urandom_range(9);
        if (r < 2)
            return $urandom_range(0, 120);
        if (r < 4)
            return $urandom_range(65400, 65535);
        return $urandom_range(0, 65535);
    endfunction

    // mostly short walks; a quarter use the whole 16-bit range
    function automatic int pick_delta();
        int r;
        r = $urandom_range(3);
        if (r < 2)
            return int'($urandom_range(0, 800)) - 400;
        if (r == 2)
            return int'($urandom_range(0, 12000)) - 6000;
        return $urandom_range(0, 65535);
    endfunction

    // driver: fields change on the falling edge
    always @(negedge i_clk) begin
        t_cmd_item it;
        bit        next_start;
        bit        calm;
        if (armed && (!start || taken)) begin
            taken = 1'b0;
            next_start = 1'b0;
            calm = items_sent >= CALM_FIRST && items_sent < CALM_LAST;
            if (cmd_queue.size() != 0) begin
                if (cmd_queue[0].drain && due_dates.size() != 0) begin
                    // wait for the pipeline to empty
                end else if (!calm && $urandom_range(99) < IDLE_PERCENT) begin
                    // random gap
                end else begin
                    it = cmd_queue.pop_front();
                    i_cmd        <= it.op;
                    i_load_year  <= it.year;
                    i_load_month <= it.month;
                    i_load_day   <= it.day;
                    i_delta_days <= it.delta;
                    next_start = 1'b1;
                    items_sent++;
                end
            end
            start <= next_start;
        end
    end

    // monitor: handshakes sampled on the rising edge
    always @(posedge i_clk) begin
        t_date want;
        bit    progress;
        armed = i_rst_n;
        if (i_rst_n) begin
            progress = 1'b0;
            if (o_done) begin
                progress = 1'b1;
                if (due_dates.size() == 0) begin
                    report_mismatch("results outstanding", 1, 0);
                end else begin
                    want = due_dates.pop_front();
                    if (o_out_year !== want.year)
                        report_mismatch("year", o_out_year, want.year);
                    if (o_out_month !== want.month)
                        report_mismatch("month", o_out_month, want.month);
                    if (o_out_day !== want.day)
                        report_mismatch("day", o_out_day, want.day);
                    if (o_clamped !== want.clamped)
                        report_mismatch("clamped", o_clamped, want.clamped);
                end
            end
            if (start && !busy) begin
                progress = 1'b1;
                held_date = advance_date(held_date, cdas_pkg::t_cmd'(i_cmd), i_load_year,
                                         i_load_month, i_load_day, i_delta_days);
                due_dates.push_back(held_date);
                taken = 1'b1;
            end
            if (progress) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
                if (stall_cycles >= STALL_LIMIT) begin
                    $display("calendar_date_add_subtract_days_core_test: FAIL");
                    $finish;
                end
            end
        end
    end

    initial begin
        int n;
        int ops;
        cdas_pkg::t_cmd op;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_cmd        = cdas_pkg::CMD_NONE;
        i_load_year  = '0;
        i_load_month = '0;
        i_load_day   = '0;
        i_delta_days = '0;
        armed        = 1'b0;
        taken        = 1'b0;
        items_sent   = 0;
        stall_cycles = 0;
        errors       = 0;
        held_date    = '{year: 16'd0, month: cdas_pkg::MONTH_JAN, day: 5'd1, clamped: 1'b0};

        // directed: reset date, zero date, saturation, repairs, extreme counts
        queue_item(cdas_pkg::CMD_NONE, 0, 0, 0, 0);
        queue_item(cdas_pkg::CMD_ADD, 0, 0, 0, -1);           // underflow from 0-01-01
        queue_item(cdas_pkg::CMD_ADD, 0, 0, 0, 0);            // zero date kept
        queue_item(cdas_pkg::CMD_ADD, 0, 0, 0, -5);           // underflow again
        queue_item(cdas_pkg::CMD_ADD, 0, 0, 0, 1);            // back to 0-01-01
        queue_item(cdas_pkg::CMD_LOAD, 65535, 12, 31, 0);
        queue_item(cdas_pkg::CMD_ADD, 0, 0, 0, 1);            // saturates
        queue_item(cdas_pkg::CMD_SUB, 0, 0, 0, 0);
        queue_item(cdas_pkg::CMD_LOAD, 2000, 2, 29, 0, 1'b1);
        queue_item(cdas_pkg::CMD_ADD, 0, 0, 0, 365);
        queue_item(cdas_pkg::CMD_SUB, 0, 0, 0, 1);
        queue_item(cdas_pkg::CMD_LOAD, 1900, 2, 30, 0);       // day repaired to 28
        queue_item(cdas_pkg::CMD_LOAD, 0, 0, 0, 0);           // month and day 0 load as 1
        queue_item(cdas_pkg::CMD_LOAD, 100, 15, 31, 0);       // month above 12 loads as 12
        queue_item(cdas_pkg::CMD_LOAD, 2024, 4, 31, 0);
        queue_item(cdas_pkg::CMD_ADD, 0, 0, 0, 32767);
        queue_item(cdas_pkg::CMD_SUB, 0, 0, 0, -32768);       // subtracting a negative adds
        queue_item(cdas_pkg::CMD_ADD, 0, 0, 0, -32768);
        queue_item(cdas_pkg::CMD_LOAD, 65535, 1, 1, 0);
        queue_item(cdas_pkg::CMD_SUB, 0, 0, 0, -32768);
        queue_item(cdas_pkg::CMD_LOAD, 0, 12, 31, 0);
        queue_item(cdas_pkg::CMD_SUB, 0, 0, 0, 32767);
        queue_item(cdas_pkg::CMD_NONE, 65535, 15, 31, -1);
        queue_item(cdas_pkg::CMD_LOAD, 1, 3, 1, 0);
        queue_item(cdas_pkg::CMD_SUB, 0, 0, 0, 60);

        // random: a load with random content, then a few walks; some runs skip the load
        n = 0;
        while (n < RANDOM_ITEMS) begin
            if ($urandom_range(9) != 0) begin
                if ($urandom_range(6) != 0)
                    queue_item(cdas_pkg::CMD_LOAD, pick_year(), $urandom_range(1, 12),
                               $urandom_range(0, 31), $urandom_range(0, 65535),
                               $urandom_range(49) == 0);
                else
                    queue_item(cdas_pkg::CMD_LOAD, pick_year(), $urandom_range(0, 15),
                               $urandom_range(0, 31), $urandom_range(0, 65535));
                n++;
            end
            ops = $urandom_range(1, 4);
            repeat (ops) begin
                case ($urandom_range(19)) inside
                    0:       op = cdas_pkg::CMD_NONE;
                    [1:9]:   op = cdas_pkg::CMD_ADD;
                    default: op = cdas_pkg::CMD_SUB;
                endcase
                queue_item(op, $urandom_range(0, 65535), $urandom_range(0, 15),
                           $urandom_range(0, 31), pick_delta());
                n++;
            end
        end

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_queue.size() != 0 || start || due_dates.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (errors == 0)
            $display("calendar_date_add_subtract_days_core_test: PASS");
        else
            $display("calendar_date_add_subtract_days_core_test: FAIL");
        $finish;
    end

endmodule
